// ----- hw/rtl/uqpe_pkg.sv -----
// uqpe_pkg: shared types, character codes and helpers for the url query
// parameter extractor. No dependencies; used by every module of the block.
`default_nettype none

package uqpe_pkg;

	localparam int NAME_BYTES  = 16;
	localparam int LEN_W       = 5;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_NAME_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NAME_LOW    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_NAME_HIGH   = 2'd2;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] HEX_TEN  = 8'd10;

	typedef enum logic [2:0] {
		MODE_SEARCH    = 3'd0,
		MODE_EXPECT_EQ = 3'd1,
		MODE_VALUE     = 3'd2,
		MODE_ESC_HIGH  = 3'd3,
		MODE_ESC_LOW   = 3'd4,
		MODE_TAIL_HIT  = 3'd5,
		MODE_TAIL_MISS = 3'd6
	} mode_t;

	// results caused by one input word: an optional value byte, then an
	// optional terminator
	typedef struct packed {
		logic       val_valid;
		logic [7:0] val;
		logic       term_valid;
		logic       found;
	} result_pair_t;

	// non-digits are decoded as c - 'A' + 10, wrapping to 8 bits
	function automatic logic [7:0] hex_value(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9)
			return c - CH_0;
		else
			return c - CH_A + HEX_TEN;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/uqpe_front.sv -----
// uqpe_front: accepts query bytes, holds the name registers, matches the
// name window and runs the decode state machine. Depends on uqpe_pkg.
`default_nettype none

module uqpe_front #(
	parameter int NAME_MAX = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [uqpe_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [uqpe_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [7:0]                        s_tdata,
	input  wire logic                              s_tlast,
	input  wire logic                              q_full,
	output logic                                   push,
	output uqpe_pkg::result_pair_t                 push_entry
);

	localparam int SEEN_W = $clog2(NAME_MAX + 1);

	logic [uqpe_pkg::LEN_W-1:0]      name_len_q;
	logic [uqpe_pkg::CFG_DATA_W-1:0] name_lo_q;
	logic [uqpe_pkg::CFG_DATA_W-1:0] name_hi_q;

	logic [NAME_MAX-1:0][7:0] recent_q;
	logic [NAME_MAX-1:0][7:0] recent_sh;
	logic [SEEN_W-1:0]        seen_q;
	logic [SEEN_W-1:0]        seen_inc;
	logic [SEEN_W-1:0]        seen_next;
	logic [7:0]               high_q;
	logic [7:0]               high_next;
	uqpe_pkg::mode_t          mode_q;
	uqpe_pkg::mode_t          mode_next;

	logic [uqpe_pkg::NAME_BYTES-1:0][7:0] name_arr;
	logic [uqpe_pkg::LEN_W-1:0]           n_eff;
	logic                                 win_ok;
	logic                                 match;
	logic                                 accept;
	logic                                 val_valid;
	logic [7:0]                           val;
	logic [7:0]                           hex_c;
	logic                                 found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_len_q <= uqpe_pkg::LEN_W'(1);
			name_lo_q  <= '0;
			name_hi_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				uqpe_pkg::REG_NAME_LENGTH: name_len_q <= cfg_data[uqpe_pkg::LEN_W-1:0];
				uqpe_pkg::REG_NAME_LOW:    name_lo_q  <= cfg_data;
				uqpe_pkg::REG_NAME_HIGH:   name_hi_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign name_arr = {name_hi_q, name_lo_q};
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign hex_c    = uqpe_pkg::hex_value(s_tdata);

	always_comb begin
		if (name_len_q == '0)
			n_eff = uqpe_pkg::LEN_W'(1);
		else if (name_len_q > uqpe_pkg::LEN_W'(NAME_MAX))
			n_eff = uqpe_pkg::LEN_W'(NAME_MAX);
		else
			n_eff = name_len_q;
	end

	// window as it stands after taking this byte, newest at index 0
	always_comb begin
		recent_sh[0] = s_tdata;
		for (int j = 1; j < NAME_MAX; j++)
			recent_sh[j] = recent_q[j-1];
	end

	assign seen_inc = (seen_q == SEEN_W'(NAME_MAX)) ? seen_q : seen_q + 1'b1;

	// oldest window byte lines up with name byte 0
	always_comb begin
		logic [uqpe_pkg::LEN_W-1:0] idx;
		win_ok = 1'b1;
		for (int j = 0; j < NAME_MAX; j++) begin
			idx = n_eff - uqpe_pkg::LEN_W'(j) - uqpe_pkg::LEN_W'(1);
			if (uqpe_pkg::LEN_W'(j) < n_eff && recent_sh[j] != name_arr[idx[3:0]])
				win_ok = 1'b0;
		end
	end

	assign match = win_ok && (uqpe_pkg::LEN_W'(seen_inc) >= n_eff);

	always_comb begin
		mode_next = mode_q;
		seen_next = seen_q;
		high_next = high_q;
		val_valid = 1'b0;
		val       = s_tdata;
		unique case (mode_q)
			uqpe_pkg::MODE_SEARCH: begin
				seen_next = seen_inc;
				if (match)
					mode_next = uqpe_pkg::MODE_EXPECT_EQ;
			end
			uqpe_pkg::MODE_EXPECT_EQ: begin
				mode_next = (s_tdata == uqpe_pkg::CH_EQ) ? uqpe_pkg::MODE_VALUE
				                                         : uqpe_pkg::MODE_TAIL_MISS;
			end
			uqpe_pkg::MODE_VALUE: begin
				if (s_tdata == uqpe_pkg::CH_AMP)
					mode_next = uqpe_pkg::MODE_TAIL_HIT;
				else if (s_tdata == uqpe_pkg::CH_PCT)
					mode_next = uqpe_pkg::MODE_ESC_HIGH;
				else if (s_tdata == uqpe_pkg::CH_PLUS) begin
					val_valid = 1'b1;
					val       = uqpe_pkg::CH_SPACE;
				end else
					val_valid = 1'b1;
			end
			uqpe_pkg::MODE_ESC_HIGH: begin
				high_next = {hex_c[3:0], 4'h0};
				mode_next = uqpe_pkg::MODE_ESC_LOW;
			end
			uqpe_pkg::MODE_ESC_LOW: begin
				val_valid = 1'b1;
				val       = high_q + hex_c;
				mode_next = uqpe_pkg::MODE_VALUE;
			end
			uqpe_pkg::MODE_TAIL_HIT, uqpe_pkg::MODE_TAIL_MISS: ;
			default: mode_next = uqpe_pkg::MODE_SEARCH;
		endcase
	end

	assign found = mode_next inside {uqpe_pkg::MODE_VALUE, uqpe_pkg::MODE_ESC_HIGH,
	                                 uqpe_pkg::MODE_ESC_LOW, uqpe_pkg::MODE_TAIL_HIT};

	assign push                  = accept && (val_valid || s_tlast);
	assign push_entry.val_valid  = val_valid;
	assign push_entry.val        = val;
	assign push_entry.term_valid = s_tlast;
	assign push_entry.found      = found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= uqpe_pkg::MODE_SEARCH;
			seen_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				mode_q <= uqpe_pkg::MODE_SEARCH;
				seen_q <= '0;
			end else begin
				mode_q <= mode_next;
				seen_q <= seen_next;
			end
		end
	end

	// window bytes are only compared once seen_q covers them
	always_ff @(posedge clk) begin
		if (accept && mode_q == uqpe_pkg::MODE_SEARCH)
			recent_q <= recent_sh;
		if (accept)
			high_q <= high_next;
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tlast) |=> (mode_q == uqpe_pkg::MODE_SEARCH && seen_q == '0))
		else $error("string end did not return parser to search");

	a_escape_low_follows_high: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !s_tlast && mode_q == uqpe_pkg::MODE_ESC_HIGH)
		|=> mode_q == uqpe_pkg::MODE_ESC_LOW)
		else $error("escape high digit not followed by low digit state");

endmodule

`default_nettype wire

// ----- hw/rtl/uqpe_queue.sv -----
// uqpe_queue: short fifo of result pairs between the parser and the output
// stage. Depends on uqpe_pkg.
`default_nettype none

module uqpe_queue (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire uqpe_pkg::result_pair_t push_entry,
	input  wire logic                   pop,
	output uqpe_pkg::result_pair_t      head,
	output logic                        empty,
	output logic                        full
);

	uqpe_pkg::result_pair_t [uqpe_pkg::QUEUE_DEPTH-1:0] slot_q;
	logic [uqpe_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [uqpe_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [uqpe_pkg::QCNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == uqpe_pkg::QCNT_W'(uqpe_pkg::QUEUE_DEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- hw/rtl/uqpe_back.sv -----
// uqpe_back: output stage; turns each queued result pair into one or two
// output words behind a registered stream port. Depends on uqpe_pkg.
`default_nettype none

module uqpe_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire uqpe_pkg::result_pair_t head,
	input  wire logic                   empty,
	output logic                        pop,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [7:0]                  m_tdata,
	output logic                        m_tlast,
	output logic                        m_tuser
);

	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic       m_tlast_q;
	logic       m_tuser_q;
	logic       pend_valid_q;
	logic       pend_found_q;
	logic       out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign pop      = out_free && !pend_valid_q && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q   <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (out_free) begin
			if (pend_valid_q) begin
				m_tvalid_q   <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (!empty) begin
				m_tvalid_q   <= 1'b1;
				pend_valid_q <= head.val_valid && head.term_valid;
			end else
				m_tvalid_q <= 1'b0;
		end
	end

	// terminator word carries value 0; value words always flag found
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				m_tdata_q <= 8'h00;
				m_tlast_q <= 1'b1;
				m_tuser_q <= pend_found_q;
			end else if (!empty) begin
				pend_found_q <= head.found;
				if (head.val_valid) begin
					m_tdata_q <= head.val;
					m_tlast_q <= 1'b0;
					m_tuser_q <= 1'b1;
				end else begin
					m_tdata_q <= 8'h00;
					m_tlast_q <= 1'b1;
					m_tuser_q <= head.found;
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	a_pend_behind_word: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (m_tvalid_q && !m_tlast_q))
		else $error("pending terminator without value word in front");

endmodule

`default_nettype wire

// ----- hw/rtl/url_query_param_extract_core.sv -----
// url_query_param_extract_core: top level of the url query parameter
// extractor. Depends on uqpe_pkg, uqpe_front, uqpe_queue and uqpe_back.
`default_nettype none

// Takes a query string one byte per word on the s_ side (s_tlast on the
// last byte) and looks for the first place the configured name ends. When
// the next byte is '=', the value is percent-decoded ('+' gives a space)
// up to '&' or the string end and sent out one byte per word; every string
// then ends with a terminator word (m_tlast high, m_tdata zero, m_tuser
// high when the name was found followed by '='). A byte is accepted every
// clock while the four-entry result queue has room; a byte gives at most
// two output words and the output port moves one word per clock while
// m_tready is high, so a byte that yields both a value byte and the
// terminator keeps the output busy for both words. An accepted byte's
// first word passes the result queue and the output register before it
// appears on m_tvalid. Configuration writes go through cfg_we /
// cfg_index / cfg_data and should be done while no string is in flight.
module url_query_param_extract_core #(
	parameter int NAME_MAX = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [uqpe_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [uqpe_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [7:0]                       s_tdata,  // query_byte
	input  wire logic                             s_tlast,  // string_end
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [7:0]                            m_tdata,  // value_byte
	output logic                                  m_tlast,  // value_done
	output logic                                  m_tuser   // name_found
);

	uqpe_pkg::result_pair_t push_entry;
	uqpe_pkg::result_pair_t head;
	logic                   push;
	logic                   pop;
	logic                   q_empty;
	logic                   q_full;

	uqpe_front #(
		.NAME_MAX (NAME_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	uqpe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty),
		.full       (q_full)
	);

	uqpe_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

// ----- test/tb_url_query_param_extract_core.sv -----
// tb_url_query_param_extract_core: self-checking stream testbench for the url query
// parameter extractor; depends on uqpe_pkg and url_query_param_extract_core only.
`timescale 1ns / 100ps

module tb_url_query_param_extract_core;

	localparam logic [uqpe_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_PAD      = 16;
	localparam int PHASE_WORDS    = 230;
	localparam int HOLD_CYCLES    = 400;

	typedef struct packed {
		logic [7:0] value;
		logic       done;
		logic       found;
	} out_word_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_we;
	logic [uqpe_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [uqpe_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [7:0]                       s_tdata;
	logic                             s_tlast;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [7:0]                       m_tdata;
	logic                             m_tlast;
	logic                             m_tuser;

	// local copy of the block's registers and parser state
	logic [4:0]      name_len_reg;
	logic [63:0]     name_lo_reg;
	logic [63:0]     name_hi_reg;
	logic [7:0]      window_q [uqpe_pkg::NAME_BYTES];
	int              seen_cnt;
	uqpe_pkg::mode_t parse_state;
	logic [7:0]      esc_high;

	out_word_t   decoded_q [$];
	logic [7:0]  query_q [$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int err_cnt;
	int words_sent;
	int strings_sent;
	int value_cnt;
	int found_cnt;
	int term_cnt;
	int settings_cnt;
	int stall_cnt;

	url_query_param_extract_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int name_len_eff();
		if (name_len_reg == 5'd0)
			return 1;
		if (name_len_reg > uqpe_pkg::NAME_BYTES)
			return uqpe_pkg::NAME_BYTES;
		return int'(name_len_reg);
	endfunction

	function automatic logic [7:0] name_char(input int i);
		if (i < 8)
			return name_lo_reg[8*i +: 8];
		return name_hi_reg[8*(i-8) +: 8];
	endfunction

	// anything outside '0'..'9' counts as a letter digit, wrapping mod 256
	function automatic logic [7:0] digit_of(input logic [7:0] c);
		logic [7:0] letter_ofs;
		letter_ofs = uqpe_pkg::HEX_TEN - uqpe_pkg::CH_A;
		return (c >= uqpe_pkg::CH_0 && c <= uqpe_pkg::CH_9) ? c - uqpe_pkg::CH_0
		                                                    : c + letter_ofs;
	endfunction

	function automatic logic window_hit();
		int n;
		n = name_len_eff();
		if (seen_cnt < n)
			return 1'b0;
		for (int i = 0; i < n; i++)
			if (window_q[n-1-i] != name_char(i))
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void clear_parser();
		foreach (window_q[i])
			window_q[i] = 8'h00;
		seen_cnt = 0;
		parse_state = uqpe_pkg::MODE_SEARCH;
		esc_high = 8'h00;
	endfunction

	function automatic void push_value(input logic [7:0] v);
		decoded_q.push_back('{value: v, done: 1'b0, found: 1'b1});
		value_cnt++;
	endfunction

	function automatic void decode_byte(input logic [7:0] c, input logic last);
		logic [7:0] d;
		logic       hit;
		case (parse_state)
			uqpe_pkg::MODE_SEARCH: begin
				for (int i = uqpe_pkg::NAME_BYTES - 1; i > 0; i--)
					window_q[i] = window_q[i-1];
				window_q[0] = c;
				if (seen_cnt < uqpe_pkg::NAME_BYTES)
					seen_cnt++;
				if (window_hit())
					parse_state = uqpe_pkg::MODE_EXPECT_EQ;
			end
			uqpe_pkg::MODE_EXPECT_EQ: begin
				parse_state = (c == uqpe_pkg::CH_EQ) ? uqpe_pkg::MODE_VALUE
				                                     : uqpe_pkg::MODE_TAIL_MISS;
			end
			uqpe_pkg::MODE_VALUE: begin
				if (c == uqpe_pkg::CH_AMP)
					parse_state = uqpe_pkg::MODE_TAIL_HIT;
				else if (c == uqpe_pkg::CH_PCT)
					parse_state = uqpe_pkg::MODE_ESC_HIGH;
				else if (c == uqpe_pkg::CH_PLUS)
					push_value(uqpe_pkg::CH_SPACE);
				else
					push_value(c);
			end
			uqpe_pkg::MODE_ESC_HIGH: begin
				d = digit_of(c);
				esc_high = {d[3:0], 4'h0};
				parse_state = uqpe_pkg::MODE_ESC_LOW;
			end
			uqpe_pkg::MODE_ESC_LOW: begin
				push_value(esc_high + digit_of(c));
				parse_state = uqpe_pkg::MODE_VALUE;
			end
			default: begin
			end
		endcase
		if (last) begin
			hit = (parse_state == uqpe_pkg::MODE_VALUE ||
				parse_state == uqpe_pkg::MODE_ESC_HIGH ||
				parse_state == uqpe_pkg::MODE_ESC_LOW ||
				parse_state == uqpe_pkg::MODE_TAIL_HIT);
			decoded_q.push_back('{value: 8'h00, done: 1'b1, found: hit});
			term_cnt++;
			if (hit)
				found_cnt++;
			clear_parser();
		end
	endfunction

	// register writes and accepted input words update the local model
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					uqpe_pkg::REG_NAME_LENGTH:
						name_len_reg = cfg_data[uqpe_pkg::LEN_W-1:0];
					uqpe_pkg::REG_NAME_LOW:    name_lo_reg = cfg_data;
					uqpe_pkg::REG_NAME_HIGH:   name_hi_reg = cfg_data;
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready)
				decode_byte(s_tdata, s_tlast);
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		err_cnt++;
	endtask

	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (decoded_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word data=%02h last=%b user=%b",
					m_tdata, m_tlast, m_tuser));
			end else begin
				want = decoded_q.pop_front();
				if (m_tdata !== want.value)
					report_mismatch($sformatf("value_byte got %02h want %02h",
						m_tdata, want.value));
				if (m_tlast !== want.done)
					report_mismatch($sformatf("value_done got %b want %b",
						m_tlast, want.done));
				if (m_tuser !== want.found)
					report_mismatch($sformatf("name_found got %b want %b",
						m_tuser, want.found));
			end
		end
	end

	// receiver: random stalls, or a counted hold-off when one is requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("FAIL url_query_param_extract_core");
			$finish;
		end
	end

	task automatic send_word(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic send_query();
		foreach (query_q[i])
			send_word(query_q[i], i == query_q.size() - 1);
		query_q.delete();
		strings_sent++;
	endtask

	// stop offering and let every expected word come out
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic write_config(input logic [4:0] len, input logic [63:0] lo,
		input logic [63:0] hi, input bit poke_unused);
		logic [uqpe_pkg::CFG_INDEX_W-1:0] idx [4];
		logic [uqpe_pkg::CFG_DATA_W-1:0]  val [4];
		int                               first;
		idx = '{REG_UNUSED, uqpe_pkg::REG_NAME_LENGTH, uqpe_pkg::REG_NAME_LOW,
			uqpe_pkg::REG_NAME_HIGH};
		val = '{{$urandom, $urandom}, {59'd0, len}, lo, hi};
		first = poke_unused ? 0 : 1;
		for (int k = first; k < 4; k++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= val[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_cnt++;
	endtask

	function automatic logic [7:0] rand_letter();
		return 8'h61 + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return uqpe_pkg::CH_0 + 8'($urandom_range(9));
		if (r < 80)
			return uqpe_pkg::CH_A + 8'($urandom_range(5));
		if (r < 90)
			return 8'h61 + 8'($urandom_range(5));
		return 8'($urandom_range(255));
	endfunction

	function automatic void add_value();
		int unsigned r;
		repeat ($urandom_range(6)) begin
			r = $urandom_range(99);
			if (r < 40) begin
				query_q.push_back(rand_letter());
			end else if (r < 55) begin
				query_q.push_back(uqpe_pkg::CH_PLUS);
			end else if (r < 80) begin
				query_q.push_back(uqpe_pkg::CH_PCT);
				query_q.push_back(rand_hex_char());
				query_q.push_back(rand_hex_char());
			end else if (r < 88) begin
				query_q.push_back(uqpe_pkg::CH_PCT);
				query_q.push_back(8'($urandom_range(255)));
				query_q.push_back(8'($urandom_range(255)));
			end else begin
				query_q.push_back(8'($urandom_range(255)));
			end
		end
	endfunction

	// mostly well-formed queries around the configured name, plus noise
	function automatic void build_query();
		int unsigned r;
		int          n;
		n = name_len_eff();
		repeat ($urandom_range(2)) begin
			repeat ($urandom_range(1, 4)) query_q.push_back(rand_letter());
			query_q.push_back(uqpe_pkg::CH_EQ);
			repeat ($urandom_range(3)) query_q.push_back(rand_letter());
			query_q.push_back(uqpe_pkg::CH_AMP);
		end
		r = $urandom_range(99);
		if (r < 70) begin
			for (int i = 0; i < n; i++)
				query_q.push_back(name_char(i));
			r = $urandom_range(9);
			if (r > 1) begin
				query_q.push_back(uqpe_pkg::CH_EQ);
				add_value();
				r = $urandom_range(9);
				if (r == 0) begin
					query_q.push_back(uqpe_pkg::CH_PCT);
				end else if (r == 1) begin
					query_q.push_back(uqpe_pkg::CH_PCT);
					query_q.push_back(rand_hex_char());
				end else if (r < 5) begin
					query_q.push_back(uqpe_pkg::CH_AMP);
					repeat ($urandom_range(4)) query_q.push_back(8'($urandom_range(255)));
				end
			end else if (r == 1) begin
				// byte after the name is usually not '='
				query_q.push_back(8'($urandom_range(255)));
				repeat ($urandom_range(3)) query_q.push_back(rand_letter());
			end
		end else if (r < 85) begin
			repeat ($urandom_range(1, 12)) query_q.push_back(8'($urandom_range(255)));
		end else begin
			for (int i = 0; i < $urandom_range(n - 1); i++)
				query_q.push_back(name_char(i));
			repeat ($urandom_range(3)) query_q.push_back(rand_letter());
			if ($urandom_range(1))
				query_q.push_back(uqpe_pkg::CH_EQ);
		end
		if (query_q.size() == 0)
			query_q.push_back(8'($urandom_range(255)));
	endfunction

	function automatic void load_query(input string s, input int zero_at);
		for (int i = 0; i < s.len(); i++)
			query_q.push_back(i == zero_at ? 8'h00 : s[i]);
	endfunction

	// reset name is one zero byte: zero bytes match like any other
	task automatic test_zero_byte_name();
		query_q.push_back(8'h00);
		query_q.push_back(uqpe_pkg::CH_EQ);
		query_q.push_back(8'hFF);
		send_query();
		wait_idle();
	endtask

	task automatic test_directed_cases();
		write_config(5'd2, 64'h6261, 64'h0, 1'b0);
		// escape digits taken from '&' and '+', then '&' ends the value
		load_query("ab=+%&+&", -1);
		send_query();
		// name followed by another byte
		load_query("abx", -1);
		send_query();
		// name on the last byte
		load_query("ab", -1);
		send_query();
		// escape cut off after one digit
		load_query("ab=%9", -1);
		send_query();
		// name never seen
		load_query("z", -1);
		send_query();
		wait_idle();
	endtask

	task automatic test_random_phase(input logic [4:0] len, input logic [63:0] lo,
		input logic [63:0] hi, input int s_idle, input int r_idle, input bit poke_unused);
		int start;
		wait_idle();
		write_config(len, lo, hi, poke_unused);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		start = words_sent;
		while (words_sent - start < PHASE_WORDS) begin
			build_query();
			send_query();
		end
	endtask

	// receiver holds off while the sender keeps offering, so the input backs up
	task automatic test_output_backpressure();
		int start;
		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = HOLD_CYCLES;
		start = words_sent;
		while (words_sent - start < 60) begin
			build_query();
			send_query();
		end
		wait_idle();
	endtask

	function automatic logic [63:0] letter_word();
		logic [63:0] w;
		for (int i = 0; i < 8; i++)
			w[8*i +: 8] = rand_letter();
		return w;
	endfunction

	initial begin
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= uqpe_pkg::REG_NAME_LENGTH;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= 8'h00;
		s_tlast   <= 1'b0;
		name_len_reg = 5'd1;
		name_lo_reg  = 64'h0;
		name_hi_reg  = 64'h0;
		clear_parser();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 0;
		err_cnt = 0;
		words_sent = 0;
		strings_sent = 0;
		value_cnt = 0;
		found_cnt = 0;
		term_cnt = 0;
		settings_cnt = 1;
		stall_cnt = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_byte_name();
		test_directed_cases();

		test_random_phase(5'd16, letter_word(), letter_word(), 6, 55, 1'b1);
		test_random_phase(5'd0, letter_word(), 64'h0, 6, 55, 1'b0);
		test_random_phase(5'd31, letter_word(), letter_word(), 6, 55, 1'b0);
		test_random_phase(5'd1, 64'h0, 64'h0, 55, 6, 1'b0);
		test_random_phase(5'($urandom_range(1, 16)), letter_word(), letter_word(),
			55, 6, 1'b1);
		test_random_phase(5'($urandom_range(17, 30)), letter_word(), letter_word(),
			55, 6, 1'b0);
		test_random_phase(5'd8, {64{1'b1}}, {64{1'b1}}, 0, 0, 1'b0);
		test_random_phase(5'($urandom_range(1, 16)), {$urandom, $urandom},
			{$urandom, $urandom}, 0, 0, 1'b0);
		test_output_backpressure();

		wait_idle();
		$display("covered %0d strings (%0d bytes) over %0d name settings", strings_sent,
			words_sent, settings_cnt);
		$display("%0d decoded value bytes, %0d of %0d terminators with the name found",
			value_cnt, found_cnt, term_cnt);
		if (err_cnt == 0)
			$display("PASS url_query_param_extract_core");
		else
			$display("FAIL url_query_param_extract_core");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/uqpe_pkg.sv
hw/rtl/uqpe_front.sv
hw/rtl/uqpe_queue.sv
hw/rtl/uqpe_back.sv
hw/rtl/url_query_param_extract_core.sv
test/tb_url_query_param_extract_core.sv
